FILE: rtl/lpad_pkg.sv
// shared types and constants for the long-press alarm dismiss controller
package lpad_pkg;

  // hold time granularity
  localparam int unsigned MsPerSecond = 1000;

  // field and state widths
  localparam int unsigned FuncW      = 2;
  localparam int unsigned CauseW     = 2;
  localparam int unsigned SecondsW   = 8;
  localparam int unsigned MaxOnW     = 24;
  localparam int unsigned BeepW      = 16;
  localparam int unsigned AlarmW     = 25;
  localparam int unsigned HeldW      = 18;
  localparam int unsigned HeldSubW   = $clog2(MsPerSecond + 1);

  // apb port
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 4;

  // item function codes
  localparam logic [FuncW-1:0] FuncMsTick   = 2'd0;
  localparam logic [FuncW-1:0] FuncHalfTick = 2'd1;
  localparam logic [FuncW-1:0] FuncStart    = 2'd2;
  localparam logic [FuncW-1:0] FuncUnused   = 2'd3;

  // end causes
  localparam logic [CauseW-1:0] CauseNone      = 2'd0;
  localparam logic [CauseW-1:0] CauseLongPress = 2'd1;
  localparam logic [CauseW-1:0] CauseTimeout   = 2'd2;

  // register reset values
  localparam logic [SecondsW-1:0] LongPressReset = 8'd25;
  localparam logic [MaxOnW-1:0]   MaxOnReset     = 24'd3600000;
  localparam logic [BeepW-1:0]    BeepLenReset   = 16'd500;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             button_active;
  } in_item_t;

  typedef struct packed {
    logic                buzzer_out;
    logic                led_out;
    logic                alarm_active;
    logic                buzzer_paused;
    logic [SecondsW-1:0] countdown_seconds;
    logic                countdown_changed;
    logic [CauseW-1:0]   end_cause;
  } out_item_t;

endpackage

FILE: rtl/long_press_alarm_dismiss_controller_core.sv
// top level of the long-press alarm dismiss controller
//
// Every input item (millisecond tick, buzzer half-period tick or alarm start, plus the
// debounced button level) yields exactly one result item. Combinational logic reads
// the alarm state registers, and the updated state and the result are stored at the
// accepting clock edge, so a new item can be taken in every cycle while in_stall_o is
// low. Results leave through an output register backed by one skid entry; in_stall_o
// only rises when both are full, i.e. when the output side has stalled for two items.
// Registers at byte addresses 0 (long_press_seconds), 4 (max_on_ms) and 8
// (beep_length_ms) must be written through the apb port only while the block is idle;
// the block does not enforce this. Reads return the stored value. The hold threshold
// is long_press_seconds times 1000 ms; a hold must exceed it to end the alarm.
module long_press_alarm_dismiss_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lpad_pkg::in_item_t                in_data_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lpad_pkg::out_item_t               out_data_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpad_pkg::ApbAddrW-1:0]     paddr,
  input  logic [lpad_pkg::ApbDataW-1:0]     pwdata,
  output logic [lpad_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  // register indexes on paddr[3:2]
  localparam logic [1:0] RegLongPress = 2'd0;
  localparam logic [1:0] RegMaxOn     = 2'd1;
  localparam logic [1:0] RegBeepLen   = 2'd2;

  localparam logic [lpad_pkg::AlarmW-1:0] AlarmMax = '1;
  localparam logic [lpad_pkg::HeldW-1:0]  HeldMax  = '1;
  localparam logic [lpad_pkg::BeepW-1:0]  BeepMax  = '1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [lpad_pkg::SecondsW-1:0] long_press_q;
  logic [lpad_pkg::MaxOnW-1:0]   max_on_q;
  logic [lpad_pkg::BeepW-1:0]    beep_len_q;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= lpad_pkg::LongPressReset;
      max_on_q     <= lpad_pkg::MaxOnReset;
      beep_len_q   <= lpad_pkg::BeepLenReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegLongPress: long_press_q <= pwdata[lpad_pkg::SecondsW-1:0];
        RegMaxOn:     max_on_q     <= pwdata[lpad_pkg::MaxOnW-1:0];
        RegBeepLen:   beep_len_q   <= pwdata[lpad_pkg::BeepW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegLongPress: prdata = lpad_pkg::ApbDataW'(long_press_q);
      RegMaxOn:     prdata = lpad_pkg::ApbDataW'(max_on_q);
      RegBeepLen:   prdata = lpad_pkg::ApbDataW'(beep_len_q);
      default:      prdata = '0;
    endcase
  end

  // hold threshold in ms, fits the held counter width
  logic [lpad_pkg::HeldW-1:0] hold_limit;
  assign hold_limit = lpad_pkg::HeldW'(long_press_q * lpad_pkg::HeldW'(lpad_pkg::MsPerSecond));

  // ---------------------------------------------------------------------------
  // alarm state
  // ---------------------------------------------------------------------------
  logic                            running_q, running_d;
  logic                            paused_q, paused_d;
  logic [lpad_pkg::AlarmW-1:0]     alarm_ms_q, alarm_ms_d;
  logic [lpad_pkg::HeldW-1:0]      held_q, held_d;
  logic [lpad_pkg::HeldSubW-1:0]   held_sub_q, held_sub_d;
  logic [lpad_pkg::SecondsW-1:0]   countdown_q, countdown_d;
  logic [lpad_pkg::BeepW-1:0]      beep_ms_q, beep_ms_d;
  logic                            wave_q, wave_d;
  logic                            beep_lvl_q, beep_lvl_d;
  logic [lpad_pkg::CauseW-1:0]     cause;
  lpad_pkg::out_item_t             result;
  logic                            in_accept;

  always_comb begin
    logic tick;
    logic pressed;
    tick        = (in_data_i.func == lpad_pkg::FuncMsTick);
    pressed     = in_data_i.button_active;
    running_d   = running_q;
    paused_d    = paused_q;
    alarm_ms_d  = alarm_ms_q;
    held_d      = held_q;
    held_sub_d  = held_sub_q;
    countdown_d = countdown_q;
    beep_ms_d   = beep_ms_q;
    wave_d      = wave_q;
    beep_lvl_d  = beep_lvl_q;
    cause       = lpad_pkg::CauseNone;

    if (in_data_i.func != lpad_pkg::FuncUnused) begin
      // timers advance before the button is looked at
      if (tick) begin
        if (beep_ms_d != BeepMax) beep_ms_d = beep_ms_d + 1'b1;
        if (running_d && alarm_ms_d != AlarmMax) alarm_ms_d = alarm_ms_d + 1'b1;
      end else if (in_data_i.func == lpad_pkg::FuncStart) begin
        // start or restart, levels kept
        running_d   = 1'b1;
        paused_d    = 1'b0;
        alarm_ms_d  = '0;
        held_d      = '0;
        held_sub_d  = '0;
        countdown_d = long_press_q;
      end

      if (running_d) begin
        if (pressed) begin
          if (!paused_d) begin
            // first pressed item silences the buzzer
            paused_d   = 1'b1;
            wave_d     = 1'b0;
            beep_lvl_d = 1'b0;
            held_d     = '0;
            held_sub_d = '0;
          end else if (tick) begin
            if (held_d != HeldMax) held_d = held_d + 1'b1;
            held_sub_d = held_sub_d + 1'b1;
            if (held_sub_d >= lpad_pkg::HeldSubW'(lpad_pkg::MsPerSecond)) begin
              held_sub_d = '0;
              if (countdown_d != '0) countdown_d = countdown_d - 1'b1;
            end
          end
          if (held_d > hold_limit) begin
            running_d = 1'b0;
            paused_d  = 1'b0;
            cause     = lpad_pkg::CauseLongPress;
          end
        end else begin
          // released: buzzer back on, countdown reloads
          paused_d    = 1'b0;
          held_d      = '0;
          held_sub_d  = '0;
          countdown_d = long_press_q;
          if (alarm_ms_d > lpad_pkg::AlarmW'(max_on_q)) begin
            wave_d     = 1'b0;
            beep_lvl_d = 1'b0;
            running_d  = 1'b0;
            cause      = lpad_pkg::CauseTimeout;
          end
        end
      end

      // square wave and beep gating only while the buzzer is on
      if (in_data_i.func == lpad_pkg::FuncHalfTick && running_d && !paused_d) begin
        if (beep_ms_d > beep_len_q || beep_ms_d == BeepMax) begin
          beep_lvl_d = !beep_lvl_d;
          beep_ms_d  = '0;
        end
        wave_d = !wave_d;
      end
    end

    result.buzzer_out        = wave_d && beep_lvl_d;
    result.led_out           = beep_lvl_d;
    result.alarm_active      = running_d;
    result.buzzer_paused     = paused_d;
    result.countdown_seconds = countdown_d;
    result.countdown_changed = (countdown_d != countdown_q);
    result.end_cause         = cause;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      paused_q    <= 1'b0;
      alarm_ms_q  <= '0;
      held_q      <= '0;
      held_sub_q  <= '0;
      countdown_q <= '0;
      beep_ms_q   <= BeepMax;
      wave_q      <= 1'b0;
      beep_lvl_q  <= 1'b0;
    end else if (in_accept) begin
      running_q   <= running_d;
      paused_q    <= paused_d;
      alarm_ms_q  <= alarm_ms_d;
      held_q      <= held_d;
      held_sub_q  <= held_sub_d;
      countdown_q <= countdown_d;
      beep_ms_q   <= beep_ms_d;
      wave_q      <= wave_d;
      beep_lvl_q  <= beep_lvl_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid entry
  // ---------------------------------------------------------------------------
  logic                out_valid_q;
  logic                skid_valid_q;
  lpad_pkg::out_item_t out_q;
  lpad_pkg::out_item_t skid_q;
  logic                out_take;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      // output slot frees up: skid entry moves first, else the new result
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= result;
      end
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_paused_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q |-> running_q)
    else $error("buzzer paused while alarm idle");

  a_sub_ms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_sub_q < lpad_pkg::HeldSubW'(lpad_pkg::MsPerSecond))
    else $error("sub-second hold counter out of range");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.func == lpad_pkg::FuncStart) |=> running_q)
    else $error("start item did not arm the alarm");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (paused_q == 1'b0))
    else $error("idle alarm reports a pause");

endmodule
